// File: hdl/hdt_pkg.sv
// ----------------------------------------------------------------------------
// hdt_pkg
// Shared types and constants of the huffman tree decoder: item kinds, node
// table entry layout, walk states and the result record.
// ----------------------------------------------------------------------------
package hdt_pkg;

	// item kinds carried in the input tuser
	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_DATA  = 2'd2;

	// node table entry: zero child in the low half, one child in the high half
	localparam int unsigned CHILD_W = 9;
	localparam int unsigned ENTRY_W = 2 * CHILD_W;
	localparam int unsigned NODE_W  = 8;
	localparam int unsigned LEN_W   = 24;
	localparam int unsigned BIT_IDX_W = 3;

	localparam logic [NODE_W-1:0]    HEAD_NODE = 8'd254;
	localparam logic [BIT_IDX_W-1:0] LAST_BIT  = 3'd7;

	// walk engine states
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_WALK  = 3'b010,
		ST_FLUSH = 3'b100
	} walk_state_t;

	// one decoded result on its way to the output register
	typedef struct packed {
		logic [7:0] plain_byte;
		logic       byte_valid;
		logic       chunk_done;
		logic       run_last;
	} result_t;

endpackage

// File: hdl/hdt_ram.sv
// ----------------------------------------------------------------------------
// hdt_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module hdt_ram #(
	parameter int unsigned WIDTH = 18,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hdl/hdt_out.sv
// ----------------------------------------------------------------------------
// hdt_out
// Output register of the decoder: holds one result transaction until the
// receiver takes it and tells the walk engine when the slot is free.
// ----------------------------------------------------------------------------
module hdt_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  hdt_pkg::result_t res,
	output logic             free,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // plain_byte
	output logic [1:0]       m_axis_tuser,  // byte_valid, chunk_done
	output logic             m_axis_tlast   // run_last
);

	logic             valid_q;
	hdt_pkg::result_t res_q;

	// slot is free when empty or drained in this cycle
	assign free = !valid_q || m_axis_tready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = res_q.plain_byte;
	assign m_axis_tuser  = {res_q.chunk_done, res_q.byte_valid};
	assign m_axis_tlast  = res_q.run_last;

endmodule

// File: hdl/hdt_walk.sv
// ----------------------------------------------------------------------------
// hdt_walk
// Walk engine: takes input items, writes node table entries, and walks the
// code tree one table read per code bit, holding back the latest literal so
// that the end-of-item and end-of-chunk flags can be set on it.
// ----------------------------------------------------------------------------
module hdt_walk #(
	parameter int unsigned NODE_ENTRIES = 256,
	parameter int unsigned COUNT_BITS   = 24,
	localparam int unsigned AW          = $clog2(NODE_ENTRIES)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input items
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   in_mode,
	input  logic [hdt_pkg::NODE_W-1:0]   in_entry_index,
	input  logic [hdt_pkg::CHILD_W-1:0]  in_zero_child,
	input  logic [hdt_pkg::CHILD_W-1:0]  in_one_child,
	input  logic [hdt_pkg::LEN_W-1:0]    in_expected_length,
	input  logic [7:0]                   in_code_byte,
	input  logic                         in_final_byte,
	// node table port
	output logic                         wr_en,
	output logic [AW-1:0]                wr_addr,
	output logic [hdt_pkg::ENTRY_W-1:0]  wr_data,
	output logic                         rd_en,
	output logic [AW-1:0]                rd_addr,
	input  logic [hdt_pkg::ENTRY_W-1:0]  rd_data,
	// result push
	input  logic                         out_free,
	output logic                         push,
	output hdt_pkg::result_t             res
);

	localparam logic [hdt_pkg::NODE_W:0] NODE_LIMIT = (hdt_pkg::NODE_W + 1)'(NODE_ENTRIES);

	hdt_pkg::walk_state_t state_q;
	logic [hdt_pkg::NODE_W-1:0]    walk_node_q;
	logic [COUNT_BITS-1:0]         produced_q;
	logic [COUNT_BITS-1:0]         target_q;
	logic                          closed_q;
	logic                          pend_valid_q;
	logic [7:0]                    pend_byte_q;
	logic                          pend_done_q;
	logic [7:0]                    code_q;
	logic                          fin_q;
	logic [hdt_pkg::BIT_IDX_W-1:0] bit_q;
	logic                          oob_s1;

	logic                          accept;
	logic                          start_walk;
	logic                          step;
	logic                          flush;
	logic [hdt_pkg::CHILD_W-1:0]   child;
	logic                          is_lit;
	logic [COUNT_BITS-1:0]         prod_inc;
	logic                          done_now;
	logic [hdt_pkg::NODE_W-1:0]    next_node;
	logic                          last_step;
	logic                          fin_eff;
	logic [hdt_pkg::NODE_W-1:0]    rd_node;

	assign in_ready   = (state_q == hdt_pkg::ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign start_walk = accept && (in_mode == hdt_pkg::MODE_DATA) && !closed_q;
	assign step       = (state_q == hdt_pkg::ST_WALK) && out_free;
	assign flush      = (state_q == hdt_pkg::ST_FLUSH) && out_free;

	// load items write the node table
	assign wr_en   = accept && (in_mode == hdt_pkg::MODE_LOAD)
		&& ({1'b0, in_entry_index} < NODE_LIMIT);
	assign wr_addr = in_entry_index[AW-1:0];
	assign wr_data = {in_one_child, in_zero_child};

	// child selection from the entry read for the current bit
	always_comb begin
		child = code_q[bit_q] ? rd_data[hdt_pkg::ENTRY_W-1:hdt_pkg::CHILD_W]
			: rd_data[hdt_pkg::CHILD_W-1:0];
		if (oob_s1) begin
			child = '0;
		end
	end

	assign is_lit    = !child[hdt_pkg::CHILD_W-1];
	assign prod_inc  = produced_q + 1'b1;
	assign done_now  = is_lit && (prod_inc == target_q);
	assign next_node = is_lit ? hdt_pkg::HEAD_NODE : child[hdt_pkg::NODE_W-1:0];
	assign last_step = (bit_q == hdt_pkg::LAST_BIT) || done_now;
	assign fin_eff   = fin_q && !closed_q;

	// table read: first bit on accept, then chained from the selected child
	assign rd_node = start_walk ? walk_node_q : next_node;
	assign rd_en   = start_walk || (step && !last_step);
	assign rd_addr = rd_node[AW-1:0];

	// result push: the held literal leaves when a newer one arrives or at flush
	always_comb begin
		push = 1'b0;
		res  = '0;
		if (step && is_lit && pend_valid_q) begin
			push           = 1'b1;
			res.plain_byte = pend_byte_q;
			res.byte_valid = 1'b1;
			res.chunk_done = pend_done_q;
		end else if (flush && pend_valid_q) begin
			push           = 1'b1;
			res.plain_byte = pend_byte_q;
			res.byte_valid = 1'b1;
			res.chunk_done = pend_done_q || fin_eff;
			res.run_last   = 1'b1;
		end else if (flush && fin_eff) begin
			push           = 1'b1;
			res.chunk_done = 1'b1;
			res.run_last   = 1'b1;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= hdt_pkg::ST_IDLE;
			walk_node_q  <= hdt_pkg::HEAD_NODE;
			produced_q   <= '0;
			target_q     <= '0;
			closed_q     <= 1'b1;
			pend_valid_q <= 1'b0;
		end else begin
			case (state_q)
				hdt_pkg::ST_IDLE: begin
					if (accept && (in_mode == hdt_pkg::MODE_START)) begin
						walk_node_q <= hdt_pkg::HEAD_NODE;
						produced_q  <= '0;
						target_q    <= COUNT_BITS'(in_expected_length);
						closed_q    <= (COUNT_BITS'(in_expected_length) == '0);
					end
					if (start_walk) begin
						state_q <= hdt_pkg::ST_WALK;
					end
				end
				hdt_pkg::ST_WALK: begin
					if (step) begin
						walk_node_q <= next_node;
						if (is_lit) begin
							produced_q   <= prod_inc;
							pend_valid_q <= 1'b1;
						end
						if (done_now) begin
							closed_q <= 1'b1;
						end
						if (last_step) begin
							state_q <= hdt_pkg::ST_FLUSH;
						end
					end
				end
				hdt_pkg::ST_FLUSH: begin
					if (flush) begin
						pend_valid_q <= 1'b0;
						closed_q     <= closed_q || fin_q;
						state_q      <= hdt_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= hdt_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// per-item payload and read tracking
	always_ff @(posedge clk) begin
		if (start_walk) begin
			code_q <= in_code_byte;
			fin_q  <= in_final_byte;
			bit_q  <= '0;
		end else if (step && !last_step) begin
			bit_q <= bit_q + 1'b1;
		end
		if (rd_en) begin
			oob_s1 <= ({1'b0, rd_node} >= NODE_LIMIT);
		end
		if (step && is_lit) begin
			pend_byte_q <= child[7:0];
			pend_done_q <= done_now;
		end
	end

`ifndef NO_ASSERTIONS
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result pushed into a full output register");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hdt_pkg::ST_IDLE) |-> !pend_valid_q)
		else $error("literal left behind after an item finished");

	a_final_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(flush && fin_q) |=> closed_q)
		else $error("final byte did not close the chunk");

	a_count_below: assert property (@(posedge clk) disable iff (!arst_n)
		!closed_q |-> (produced_q < target_q))
		else $error("open chunk with count at or beyond target");
`endif

endmodule

// File: hdl/huffman_tree_decoder.sv
// ----------------------------------------------------------------------------
// huffman_tree_decoder
// Huffman decoder walking a code tree held in a node table memory.
// ----------------------------------------------------------------------------
// Usage: input transactions on s_axis select by tuser: load a node entry,
// start a chunk with its expected length, or feed one compressed byte (tlast
// marks the final byte of the chunk). Decoded bytes leave on m_axis, one per
// transaction, with tuser flags byte_valid and chunk_done and tlast on the
// last result caused by an input transaction.
// Load and start transactions complete in the idle state. A data byte is
// accepted, then walked with one node table read per code bit (up to eight,
// each read chained from the child selected for the bit before), and then
// the held literal is handed over in the flush state. Results appear from
// the second code bit onward; a byte's last result leaves in that flush state.
// The node table content is undefined after reset and must be loaded before
// use; reset leaves the chunk closed with the walk at the head node.
// When the receiver stalls, the walk holds in place until the output
// register frees, and s_axis stays not ready until the byte is finished.
// ----------------------------------------------------------------------------
module huffman_tree_decoder #(
	parameter int unsigned NODE_ENTRIES = 256,
	parameter int unsigned COUNT_BITS   = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// entry_index, zero_child, one_child, expected_length, code_byte, zero pad
	input  logic [63:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,  // mode
	input  logic        s_axis_tlast,  // final_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // plain_byte
	output logic [1:0]  m_axis_tuser,  // byte_valid, chunk_done
	output logic        m_axis_tlast   // run_last
);

	localparam int unsigned AW = $clog2(NODE_ENTRIES);

	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic [hdt_pkg::ENTRY_W-1:0] wr_data;
	logic                        rd_en;
	logic [AW-1:0]               rd_addr;
	logic [hdt_pkg::ENTRY_W-1:0] rd_data;
	logic                        out_free;
	logic                        push;
	hdt_pkg::result_t            res;

	// node table
	hdt_ram #(
		.WIDTH(hdt_pkg::ENTRY_W),
		.DEPTH(NODE_ENTRIES)
	) u_node_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// walk engine
	hdt_walk #(
		.NODE_ENTRIES(NODE_ENTRIES),
		.COUNT_BITS  (COUNT_BITS)
	) u_walk (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (s_axis_tvalid),
		.in_ready          (s_axis_tready),
		.in_mode           (s_axis_tuser),
		.in_entry_index    (s_axis_tdata[7:0]),
		.in_zero_child     (s_axis_tdata[16:8]),
		.in_one_child      (s_axis_tdata[25:17]),
		.in_expected_length(s_axis_tdata[49:26]),
		.in_code_byte      (s_axis_tdata[57:50]),
		.in_final_byte     (s_axis_tlast),
		.wr_en             (wr_en),
		.wr_addr           (wr_addr),
		.wr_data           (wr_data),
		.rd_en             (rd_en),
		.rd_addr           (rd_addr),
		.rd_data           (rd_data),
		.out_free          (out_free),
		.push              (push),
		.res               (res)
	);

	// output register
	hdt_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.res          (res),
		.free         (out_free),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule
